### src/bffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg: shared types and constants for the bitmap first-free allocator
// Bitmap geometry, command codes, FSM states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // Bitmap geometry
    localparam int BITMAP_BYTES    = 8192;
    localparam int DATA_START_BYTE = 8;

    // Bytes per memory word (64-bit rows)
    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int WORDS      = (BITMAP_BYTES + LANES - 1) / LANES;
    localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TAIL_LANES = BITMAP_BYTES - (WORDS - 1) * LANES;
    localparam bit START_PAST_END = (DATA_START_BYTE >= BITMAP_BYTES);

    // Field widths
    localparam int BYTE_ADDR_W = 13;
    localparam int BLK_W       = 17;

    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(WORDS - 1);
    localparam logic [WORD_AW-1:0] START_WORD = WORD_AW'(DATA_START_BYTE / LANES);
    localparam logic [LANE_W-1:0]  START_LANE = LANE_W'(DATA_START_BYTE % LANES);
    localparam logic [BLK_W-1:0]   NONE_IDX   = BLK_W'(BITMAP_BYTES * 8);

    // Request command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   cmd;
        logic                   data_region;
        logic [BYTE_ADDR_W-1:0] byte_addr;
        logic [7:0]             byte_value;
    } t_req;

    // Controller -> datapath
    typedef struct packed {
        logic clear;    // zero one memory row of the clearing pass
        logic start;    // begin an allocate scan
        logic scan;     // issue next row read
        logic emit;     // load result register, write back claimed byte
        logic wr_byte;  // write one bitmap byte from the request
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

### src/bffa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_req_if: request channel
// Allocate or bitmap-byte write word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bffa_req_if;
    import bffa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic                   data_region;
    logic [BYTE_ADDR_W-1:0] byte_addr;
    logic [7:0]             byte_value;

    modport source (output valid, cmd, data_region, byte_addr, byte_value, input ready);
    modport sink   (input valid, cmd, data_region, byte_addr, byte_value, output ready);
endinterface
`default_nettype wire

### src/bffa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_rsp_if: response channel
// Allocation result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
    import bffa_pkg::*;

    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] blk_idx;
    logic             found;

    modport source (output valid, blk_idx, found, input ready);
    modport sink   (input valid, blk_idx, found, output ready);
endinterface
`default_nettype wire

### src/bffa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ctrl: allocator controller
// Sequences the clearing pass, request intake, row scan and result handoff.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_req_valid,
    input  wire              i_req_cmd,
    input  wire              i_req_region,
    output logic             o_req_ready,
    output bffa_pkg::t_dp_cmd o_cmd,
    input  bffa_pkg::t_dp_sts i_sts
);
    import bffa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid && i_req_cmd == CMD_ALLOC) begin
                    // data region lying past the bitmap: nothing to scan
                    if (i_req_region && START_PAST_END) n_state = S_DONE;
                    else                                n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.miss) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.start   = i_req_valid && (i_req_cmd == CMD_ALLOC);
                o_cmd.wr_byte = i_req_valid && (i_req_cmd == CMD_WRITE);
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DONE: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/bffa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_dp: allocator datapath
// 64-bit wide bitmap memory, row scan pipeline, bit pick and result register.
// ----------------------------------------------------------------------------
module bffa_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  bffa_pkg::t_dp_cmd              i_cmd,
    output bffa_pkg::t_dp_sts              o_sts,
    input  bffa_pkg::t_req                 i_req,
    input  wire                            i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic [bffa_pkg::BLK_W-1:0]     o_blk_idx,
    output logic                           o_found
);
    import bffa_pkg::*;

    logic [8*LANES-1:0] mem [WORDS];

    // clearing pass
    logic [WORD_AW-1:0] r_clr_addr;

    // scan pipeline
    logic [WORD_AW-1:0] r_rd_addr;
    logic               r_issue_done;
    logic               r_data_vld;
    logic [WORD_AW-1:0] r_data_word;
    logic [8*LANES-1:0] r_rd_data;
    logic               r_region;

    // claimed byte
    logic               r_found;
    logic [WORD_AW-1:0] r_hit_word;
    logic [LANE_W-1:0]  r_hit_lane;
    logic [7:0]         r_hit_byte;

    // result register
    logic               r_out_valid;
    logic [BLK_W-1:0]   r_out_idx;
    logic               r_out_found;

    logic               rd_en;
    logic [WORD_AW-1:0] first_word;
    logic [LANE_W-1:0]  first_lane;
    logic [LANES-1:0]   lane_free;
    logic               any_free;
    logic [LANE_W-1:0]  hit_lane;
    logic [LANE_W-1:0]  bit_k;
    logic [7:0]         new_byte;
    logic [BLK_W-1:0]   pick_idx;
    logic               out_free;
    logic               in_range;
    logic               mem_we;
    logic               mem_full;
    logic [WORD_AW-1:0] mem_wa;
    logic [LANE_W-1:0]  mem_wl;
    logic [7:0]         mem_wd;

    assign rd_en = i_cmd.scan && !r_issue_done;

    // ---- row check: first non-full byte lane in the current row ----
    assign first_word = r_region ? START_WORD : '0;
    assign first_lane = r_region ? START_LANE : '0;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            lane_free[j] = (r_rd_data[8*j +: 8] != 8'hFF)
                && !((r_data_word == first_word) && (LANE_W'(j) < first_lane))
                && !((r_data_word == LAST_WORD) && (j >= TAIL_LANES));
        end
    end

    assign any_free = |lane_free;

    always_comb begin
        hit_lane = '0;
        for (int j = LANES - 1; j >= 0; j--) begin
            if (lane_free[j]) hit_lane = LANE_W'(j);
        end
    end

    // ---- bit pick: msb is the lowest block ----
    always_comb begin
        bit_k = '0;
        for (int b = 7; b >= 0; b--) begin
            if (!r_hit_byte[7-b]) bit_k = LANE_W'(b);
        end
    end

    assign new_byte = r_hit_byte | (8'h80 >> bit_k);
    assign pick_idx = BLK_W'({r_hit_word, r_hit_lane, bit_k});

    assign out_free = !r_out_valid || i_rsp_ready;
    assign in_range = (32'(i_req.byte_addr) < BITMAP_BYTES);

    // ---- memory write port select ----
    always_comb begin
        mem_we   = 1'b0;
        mem_full = 1'b0;
        mem_wa   = r_clr_addr;
        mem_wl   = '0;
        mem_wd   = '0;
        if (i_cmd.clear) begin
            mem_we   = 1'b1;
            mem_full = 1'b1;
        end else if (i_cmd.wr_byte) begin
            mem_we = in_range;
            mem_wa = WORD_AW'(i_req.byte_addr >> LANE_W);
            mem_wl = i_req.byte_addr[LANE_W-1:0];
            mem_wd = i_req.byte_value;
        end else if (i_cmd.emit) begin
            mem_we = r_found;
            mem_wa = r_hit_word;
            mem_wl = r_hit_lane;
            mem_wd = new_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            if (mem_full) mem[mem_wa] <= '0;
            else          mem[mem_wa][8*mem_wl +: 8] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data   <= mem[r_rd_addr];
            r_data_word <= r_rd_addr;
        end
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_rd_addr    <= '0;
            r_issue_done <= 1'b0;
            r_data_vld   <= 1'b0;
            r_region     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear && r_clr_addr != LAST_WORD) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (i_cmd.start) begin
                r_region     <= i_req.data_region;
                r_rd_addr    <= i_req.data_region ? START_WORD : '0;
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
                r_data_vld   <= 1'b0;
            end else begin
                r_data_vld <= rd_en;
                if (rd_en) begin
                    if (r_rd_addr == LAST_WORD) r_issue_done <= 1'b1;
                    else                        r_rd_addr    <= r_rd_addr + 1'b1;
                end
                if (i_cmd.scan && r_data_vld && any_free) begin
                    r_found <= 1'b1;
                end
            end

            if (i_cmd.emit)       r_out_valid <= 1'b1;
            else if (i_rsp_ready) r_out_valid <= 1'b0;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && r_data_vld && any_free) begin
            r_hit_word <= r_data_word;
            r_hit_lane <= hit_lane;
            r_hit_byte <= r_rd_data[8*hit_lane +: 8];
        end
        if (i_cmd.emit) begin
            r_out_idx   <= r_found ? pick_idx : NONE_IDX;
            r_out_found <= r_found;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == LAST_WORD);
    assign o_sts.hit      = r_data_vld && any_free;
    assign o_sts.miss     = r_data_vld && !any_free && (r_data_word == LAST_WORD);
    assign o_sts.out_free = out_free;

    assign o_rsp_valid = r_out_valid;
    assign o_blk_idx   = r_out_idx;
    assign o_found     = r_out_found;

endmodule
`default_nettype wire

### src/bitmap_first_free_allocator_core.sv
`default_nettype none
// Allocate: after accept, 64-bit rows are read and checked one per cycle from the bitmap
//   memory read port, worst case 1024 rows; the result register is loaded once it is free.
// Write: the byte is written on accept, no result. One request in flight; result register frees intake.
// Reset: a clearing pass zeroes one row per cycle, with ready low.
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_core: first-fit block allocator over a usage bitmap
// Scans the bitmap eight bytes per cycle, claims the lowest free block.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bffa_req_if.sink   i_req,
    bffa_rsp_if.source o_rsp
);
    import bffa_pkg::*;

    t_req    req;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign req.cmd         = i_req.cmd;
    assign req.data_region = i_req.data_region;
    assign req.byte_addr   = i_req.byte_addr;
    assign req.byte_value  = i_req.byte_value;

    bffa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_cmd    (req.cmd),
        .i_req_region (req.data_region),
        .o_req_ready  (i_req.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    bffa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req         (req),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_blk_idx     (o_rsp.blk_idx),
        .o_found       (o_rsp.found)
    );

    // no request taken while the bitmap is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_req.ready)
        else $error("request accepted during clearing pass");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.start, cmd.scan, cmd.emit, cmd.wr_byte}))
        else $error("conflicting datapath commands");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_rsp.valid)
        else $error("result word not presented after emit");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.blk_idx == NONE_IDX))
        else $error("miss word carries a block index");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bitmap_first_free_allocator_core
// Drives allocate and byte-write words with random gaps and response stalls.
// A shadow copy of the usage bitmap predicts each grant, and the bench
// compares grants in order. It ends by blocking the low bytes and punching
// single holes to push scans past them.
// ----------------------------------------------------------------------------
module tb;
    import bffa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 540;
    localparam int FILL_BYTES     = 16;

    typedef struct packed {
        logic [BLK_W-1:0] blk_idx;
        logic             found;
    } t_grant;

    // Shadow bitmap plus the grants still owed by the block
    class bitmap_tracker;
        logic [7:0] usage [BITMAP_BYTES];
        t_grant     pending_grants[$];
        int         errors;

        function new();
            foreach (usage[i]) usage[i] = 8'h00;
            errors = 0;
        endfunction

        function void take_request(t_req r);
            int     b;
            int     k;
            int     first_byte;
            t_grant g;
            if (r.cmd == CMD_WRITE) begin
                if (int'(r.byte_addr) < BITMAP_BYTES) usage[r.byte_addr] = r.byte_value;
                return;
            end
            g.found   = 1'b0;
            g.blk_idx = BLK_W'(BITMAP_BYTES * 8);
            first_byte = r.data_region ? DATA_START_BYTE : 0;
            // msb of a byte is its lowest block
            for (b = first_byte; b < BITMAP_BYTES && !g.found; b++) begin
                if (usage[b] != 8'hFF) begin
                    for (k = 0; k < 8; k++) begin
                        if (!g.found && !usage[b][7-k]) begin
                            usage[b][7-k] = 1'b1;
                            g.found       = 1'b1;
                            g.blk_idx     = BLK_W'(b * 8 + k);
                        end
                    end
                end
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [BLK_W-1:0] idx, logic found);
            t_grant want;
            if (pending_grants.size() == 0) begin
                $error("unexpected grant: blk_idx=%0d found=%0b", idx, found);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            if (idx !== want.blk_idx) begin
                $error("blk_idx: expected %0d, got %0d", want.blk_idx, idx);
                errors++;
            end
            if (found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, found);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_cycles = 0;
    bit   req_burst   = 1'b0;
    bit   rsp_burst   = 1'b0;

    bffa_req_if req_bus ();
    bffa_rsp_if rsp_bus ();

    bitmap_tracker tracker = new();

    bitmap_first_free_allocator_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ends the run when nothing moves for too long
    always @(posedge clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input t_req r);
        int gap;
        if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.cmd         <= r.cmd;
        req_bus.data_region <= r.data_region;
        req_bus.byte_addr   <= r.byte_addr;
        req_bus.byte_value  <= r.byte_value;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        tracker.take_request(r);
    endtask

    // Unused fields carry random junk
    task automatic alloc(input logic region);
        t_req r;
        r.cmd         = CMD_ALLOC;
        r.data_region = region;
        r.byte_addr   = BYTE_ADDR_W'($urandom);
        r.byte_value  = 8'($urandom);
        send_word(r);
    endtask

    task automatic write_byte(input logic [BYTE_ADDR_W-1:0] addr, input logic [7:0] value);
        t_req r;
        r.cmd         = CMD_WRITE;
        r.data_region = 1'($urandom);
        r.byte_addr   = addr;
        r.byte_value  = value;
        send_word(r);
    endtask

    task automatic drain_grants();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (tracker.pending_grants.size() != 0) @(posedge clk);
    endtask

    // Response side
    initial begin
        int stall;
        rsp_bus.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
            stall = rsp_burst ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge clk);
                rsp_bus.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (rsp_bus.valid !== 1'b1);
            tracker.check_grant(rsp_bus.blk_idx, rsp_bus.found);
        end
    end

    initial begin
        int               i;
        int               pick;
        logic [BYTE_ADDR_W-1:0] addr;
        logic [7:0]       value;
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.cmd         = CMD_ALLOC;
        req_bus.data_region = 1'b0;
        req_bus.byte_addr   = '0;
        req_bus.byte_value  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fresh bitmap, both scan starts, overwrites, ignored fields
        alloc(1'b0);
        alloc(1'b1);
        alloc(1'b0);
        write_byte(13'd0, 8'hFF);
        alloc(1'b0);
        write_byte(13'd8191, 8'h00);
        write_byte(13'd1, 8'h7F);
        alloc(1'b0);
        write_byte(13'd1, 8'hFF);
        write_byte(13'd2, 8'hFE);
        alloc(1'b0);
        alloc(1'b1);
        write_byte(13'h1555, 8'hAA);
        write_byte(13'h0AAA, 8'h55);
        write_byte(13'd8, 8'hFF);
        write_byte(13'd9, 8'hF7);
        alloc(1'b1);
        alloc(1'b1);
        write_byte(13'd0, 8'h00);
        alloc(1'b0);

        // Random: writes mostly near the bottom so scans stay short
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 99) < 55) begin
                alloc(1'($urandom));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 7) addr = BYTE_ADDR_W'($urandom_range(0, 63));
                else addr = BYTE_ADDR_W'($urandom);
                pick = $urandom_range(0, 4);
                case (pick)
                    0, 1: value = 8'($urandom);
                    2: value = 8'hFF;
                    3: value = 8'h00;
                    default: value = ~(8'h80 >> $urandom_range(0, 7));
                endcase
                write_byte(addr, value);
            end
            if ($urandom_range(0, 99) == 0) drain_grants();
        end

        // Low bytes all set, then punch single holes
        drain_grants();
        for (i = 0; i < FILL_BYTES; i++) write_byte(BYTE_ADDR_W'(i), 8'hFF);
        alloc(1'b0);
        alloc(1'b1);
        write_byte(13'd8191, 8'hFE);
        alloc(1'b1);
        alloc(1'b0);
        write_byte(13'd3, 8'hEF);
        alloc(1'b1);
        alloc(1'b0);
        alloc(1'b0);

        drain_grants();
        repeat (50) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
